@@ sv/adm_pkg.sv @@
// shared constants and codes for the arcade drive mixer with tip override
package adm_pkg;

  // default accelerometer sample width
  localparam int unsigned ADC_BITS_DEF = 12;

  // quotient bits of both restoring dividers, one bit per stage
  localparam int unsigned QUO_BITS = 8;

  // configuration register widths and reset values
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [7:0]  GEAR_THR_RST = 8'd0;
  localparam logic [15:0] GEAR_DIV_RST = 16'd256;
  localparam logic [11:0] ARM_LIM_RST  = 12'd2250;
  localparam logic [14:0] TILT_COS_RST = 15'd11207;

  // smallest gear divisor, 1.0 in Q8.8
  localparam logic [15:0] GEAR_DIV_MIN = 16'd256;

  // width of the squared tilt cosine
  localparam int unsigned TC2_W = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEAR_THR = 2'd0,
    REG_GEAR_DIV = 2'd1,
    REG_ARM_LIM  = 2'd2,
    REG_TILT_COS = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_MIX     = 2'd0,
    MODE_TIP_FWD = 2'd1,
    MODE_TIP_BWD = 2'd2,
    MODE_STOP    = 2'd3
  } drive_mode_e;

endpackage

@@ sv/arcade_drive_mixer_tip_override.sv @@
// arcade drive mixer with tilt detection, top level
//
// Input channel (in_valid_i/in_ready_o) carries one control tick: two stick
// axes, the arm reading and three raw accelerometer samples. Output channel
// (out_valid_o/out_ready_i) returns left and right motor power plus the drive
// mode. Configuration is a plain write port and must be written only while
// idle by the user; the block itself does not enforce this. The block is
// a 2*QUO_BITS+4 stage pipeline (20 stages): one stage for the input
// register, eight restoring gear-divider stages, two stages to finish the
// gear rounding and form the mix terms, eight restoring mix-divider stages
// and the output register. The tilt check (squares, split product, wide
// compare) runs alongside the gear divider. Throughput is one request per
// cycle while the receiver does not stall; the one-bit-per-stage dividers
// set the depth. When the receiver stalls the whole pipeline holds and
// in_ready_o drops, so nothing is lost or repeated. Reset empties the
// pipeline and loads the configuration defaults.
module arcade_drive_mixer_tip_override #(
  parameter int unsigned ADC_BITS = adm_pkg::ADC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [adm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [7:0]             stick_forward_i,
  input  logic signed [7:0]             stick_turn_i,
  input  logic [11:0]                   arm_position_i,
  input  logic [ADC_BITS-1:0]           accel_x_i,
  input  logic [ADC_BITS-1:0]           accel_y_i,
  input  logic [ADC_BITS-1:0]           accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [7:0]             left_power_o,
  output logic signed [7:0]             right_power_o,
  output logic [1:0]                    drive_mode_o
);

  localparam int unsigned QB   = adm_pkg::QUO_BITS;
  localparam int unsigned QIW  = $clog2(QB);
  localparam int unsigned DW   = ADC_BITS + 1;
  localparam int unsigned SQW  = 2 * ADC_BITS;
  localparam int unsigned SW   = SQW + 2;
  localparam int unsigned SH   = SW / 2;
  localparam int unsigned TCW  = adm_pkg::TC2_W;
  localparam int unsigned RW   = TCW + SW;
  localparam longint unsigned FS_L = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [SW+4:0] LIM = (SW+5)'(36 * FS_L * FS_L);
  localparam int unsigned TS   = 4;
  localparam int unsigned ZR   = QB + 1;
  localparam int unsigned ML   = 2 * QB + 2;
  localparam int unsigned OUTS = 2 * QB + 3;

  typedef struct packed {
    logic              neg;
    logic              scl;
    logic signed [7:0] v;
    logic [15:0]       rem;
    logic [7:0]        quo;
  } glane_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] rem;
    logic [7:0]  quo;
  } mlane_t;

  typedef struct packed {
    logic [8:0] den;
    mlane_t     lt;
    mlane_t     rt;
  } mix_t;

  typedef struct packed {
    logic                 tipen;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } t0_t;

  typedef struct packed {
    logic           tipen;
    logic [SQW-1:0] sx;
    logic [SQW-1:0] sy;
    logic [SQW-1:0] sz;
    logic           dyneg;
    logic           dypos;
    logic [TCW-1:0] tc2;
  } t1_t;

  typedef struct packed {
    logic           tipen;
    logic [SW-1:0]  s;
    logic [SQW-1:0] sy;
    logic           dyneg;
    logic           dypos;
    logic [TCW-1:0] tc2;
  } t2_t;

  typedef struct packed {
    logic                   tipen;
    logic                   over;
    logic [TCW+SH-1:0]      plo;
    logic [TCW+SW-SH-1:0]   phi;
    logic [SQW-1:0]         sy;
    logic                   dyneg;
    logic                   dypos;
  } t3_t;

  // configuration registers
  logic [7:0]  thr_q;
  logic [15:0] gdiv_q;
  logic [11:0] arm_q;
  logic [14:0] tcos_q;
  logic [15:0] gd;

  // pipeline registers
  logic              vld_q [0:OUTS];
  glane_t            gz_q  [0:QB];
  glane_t            gr_q  [0:QB];
  glane_t            gz_d  [0:QB];
  glane_t            gr_d  [0:QB];
  logic signed [8:0] z_q, r_q, z_d, r_d;
  mix_t              mx_q  [0:QB];
  mix_t              mx_d  [0:QB];
  t0_t               t0_q, t0_d;
  t1_t               t1_q, t1_d;
  t2_t               t2_q, t2_d;
  t3_t               t3_q, t3_d;
  adm_pkg::drive_mode_e tipc_q [TS:ML];
  adm_pkg::drive_mode_e tipc_d [TS:ML];
  logic signed [7:0] left_q, left_d, right_q, right_d;
  adm_pkg::drive_mode_e mode_q, mode_d;
  logic              adv;

  // prepare a gear lane: magnitude scaled by 256
  function automatic glane_t ginit(logic signed [7:0] v, logic [7:0] thr);
    glane_t     o;
    logic [7:0] mag;
    mag   = v[7] ? 8'(-v) : 8'(v);
    o.neg = v[7];
    o.scl = mag < thr;
    o.v   = v;
    o.rem = {mag, 8'd0};
    o.quo = 8'd0;
    return o;
  endfunction

  // one restoring step of the gear division
  function automatic glane_t gstep(glane_t a, logic [15:0] g, logic [QIW-1:0] i);
    glane_t         o;
    logic [15+QB:0] dsh;
    o   = a;
    dsh = (16 + QB)'(g) << i;
    if ((16 + QB)'(a.rem) >= dsh) begin
      o.rem    = a.rem - dsh[15:0];
      o.quo[i] = 1'b1;
    end
    return o;
  endfunction

  // one restoring step of the mix division
  function automatic mlane_t mstep(mlane_t a, logic [8:0] den, logic [QIW-1:0] i);
    mlane_t         o;
    logic [15+QB:0] dsh;
    o   = a;
    dsh = (16 + QB)'(den) << i;
    if ((16 + QB)'(a.rem) >= dsh) begin
      o.rem    = a.rem - dsh[15:0];
      o.quo[i] = 1'b1;
    end
    return o;
  endfunction

  // gear result: ceiling of the scaled value, or the stick unchanged
  function automatic logic signed [8:0] gfin(glane_t a);
    logic signed [8:0] x;
    if (!a.scl) begin
      x = 9'(a.v);
    end else if (a.neg) begin
      x = -$signed({1'b0, a.quo});
    end else begin
      x = $signed({1'b0, a.quo}) + $signed({8'd0, |a.rem});
    end
    return x;
  endfunction

  // mix lane from a signed numerator
  function automatic mlane_t minit(logic signed [17:0] n);
    mlane_t            o;
    logic signed [17:0] m;
    m     = n[17] ? -n : n;
    o.neg = n[17];
    o.rem = m[15:0];
    o.quo = 8'd0;
    return o;
  endfunction

  // mix result: ceiling of the quotient, saturated
  function automatic logic signed [7:0] mfin(mlane_t a);
    logic signed [9:0] x;
    if (a.neg) begin
      x = -$signed({2'b00, a.quo});
    end else begin
      x = $signed({2'b00, a.quo}) + $signed({9'd0, |a.rem});
    end
    if (x > 10'sd127) begin
      return 8'sd127;
    end else if (x < -10'sd127) begin
      return -8'sd127;
    end
    return x[7:0];
  endfunction

  assign adv        = !vld_q[OUTS] || out_ready_i;
  assign in_ready_o = adv;
  assign gd         = (gdiv_q < adm_pkg::GEAR_DIV_MIN) ? adm_pkg::GEAR_DIV_MIN : gdiv_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= adm_pkg::GEAR_THR_RST;
      gdiv_q <= adm_pkg::GEAR_DIV_RST;
      arm_q  <= adm_pkg::ARM_LIM_RST;
      tcos_q <= adm_pkg::TILT_COS_RST;
    end else if (cfg_we_i) begin
      unique case (adm_pkg::cfg_reg_e'(cfg_idx_i))
        adm_pkg::REG_GEAR_THR: thr_q  <= cfg_data_i[7:0];
        adm_pkg::REG_GEAR_DIV: gdiv_q <= cfg_data_i[15:0];
        adm_pkg::REG_ARM_LIM:  arm_q  <= cfg_data_i[11:0];
        adm_pkg::REG_TILT_COS: tcos_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // gear divider lanes and gear finish
  always_comb begin
    gz_d[0] = ginit(stick_forward_i, thr_q);
    gr_d[0] = ginit(stick_turn_i, thr_q);
    for (int k = 1; k <= QB; k++) begin
      gz_d[k] = gstep(gz_q[k-1], gd, QIW'(QB - k));
      gr_d[k] = gstep(gr_q[k-1], gd, QIW'(QB - k));
    end
    z_d = gfin(gz_q[QB]);
    r_d = gfin(gr_q[QB]);
  end

  // mix terms and mix divider lanes
  always_comb begin
    logic [7:0]         az, ar;
    logic [15:0]        pz, pr;
    logic signed [17:0] ez, er;
    az = z_q[8] ? 8'(-z_q) : z_q[7:0];
    ar = r_q[8] ? 8'(-r_q) : r_q[7:0];
    pz = az * az;
    pr = ar * ar;
    ez = z_q[8] ? -$signed({2'b00, pz}) : $signed({2'b00, pz});
    er = r_q[8] ? -$signed({2'b00, pr}) : $signed({2'b00, pr});
    mx_d[0].den = {1'b0, az} + {1'b0, ar};
    mx_d[0].lt  = minit(ez + er);
    mx_d[0].rt  = minit(ez - er);
    for (int k = 1; k <= QB; k++) begin
      mx_d[k].den = mx_q[k-1].den;
      mx_d[k].lt  = mstep(mx_q[k-1].lt, mx_q[k-1].den, QIW'(QB - k));
      mx_d[k].rt  = mstep(mx_q[k-1].rt, mx_q[k-1].den, QIW'(QB - k));
    end
  end

  // tilt check: offsets, squares, split product, compare
  always_comb begin
    logic signed [DW:0] tx, ty, tz;
    logic [SW+4:0]      s25;
    logic [RW-1:0]      rhs, lhs;
    tx = $signed({1'b0, accel_x_i, 1'b0}) - $signed({2'b00, {ADC_BITS{1'b1}}});
    ty = $signed({1'b0, accel_y_i, 1'b0}) - $signed({2'b00, {ADC_BITS{1'b1}}});
    tz = $signed({1'b0, accel_z_i, 1'b0}) - $signed({2'b00, {ADC_BITS{1'b1}}});
    t0_d.tipen = arm_position_i < arm_q;
    t0_d.dx    = tx[DW-1:0];
    t0_d.dy    = ty[DW-1:0];
    t0_d.dz    = tz[DW-1:0];

    t1_d.tipen = t0_q.tipen;
    t1_d.sx    = SQW'(t0_q.dx * t0_q.dx);
    t1_d.sy    = SQW'(t0_q.dy * t0_q.dy);
    t1_d.sz    = SQW'(t0_q.dz * t0_q.dz);
    t1_d.dyneg = t0_q.dy[DW-1];
    t1_d.dypos = !t0_q.dy[DW-1] && (t0_q.dy != '0);
    t1_d.tc2   = tcos_q * tcos_q;

    t2_d.tipen = t1_q.tipen;
    t2_d.s     = SW'(t1_q.sx) + SW'(t1_q.sy) + SW'(t1_q.sz);
    t2_d.sy    = t1_q.sy;
    t2_d.dyneg = t1_q.dyneg;
    t2_d.dypos = t1_q.dypos;
    t2_d.tc2   = t1_q.tc2;

    s25        = (SW+5)'(t2_q.s) * (SW+5)'(25);
    t3_d.tipen = t2_q.tipen;
    t3_d.over  = s25 > LIM;
    t3_d.plo   = (TCW+SH)'(t2_q.tc2) * (TCW+SH)'(t2_q.s[SH-1:0]);
    t3_d.phi   = (TCW+SW-SH)'(t2_q.tc2) * (TCW+SW-SH)'(t2_q.s[SW-1:SH]);
    t3_d.sy    = t2_q.sy;
    t3_d.dyneg = t2_q.dyneg;
    t3_d.dypos = t2_q.dypos;

    rhs = RW'(t3_q.plo) + (RW'(t3_q.phi) << SH);
    lhs = RW'(t3_q.sy) << TCW;
    tipc_d[TS] = adm_pkg::MODE_MIX;
    if (t3_q.tipen && !t3_q.over && (lhs > rhs)) begin
      if (t3_q.dypos) begin
        tipc_d[TS] = adm_pkg::MODE_TIP_FWD;
      end else if (t3_q.dyneg) begin
        tipc_d[TS] = adm_pkg::MODE_TIP_BWD;
      end
    end
    for (int k = TS + 1; k <= ML; k++) begin
      tipc_d[k] = tipc_q[k-1];
    end
  end

  // result select: tip override, stop, or mixed drive
  always_comb begin
    if (tipc_q[ML] == adm_pkg::MODE_TIP_FWD) begin
      left_d  = 8'sd127;
      right_d = 8'sd127;
      mode_d  = adm_pkg::MODE_TIP_FWD;
    end else if (tipc_q[ML] == adm_pkg::MODE_TIP_BWD) begin
      left_d  = -8'sd127;
      right_d = -8'sd127;
      mode_d  = adm_pkg::MODE_TIP_BWD;
    end else if (mx_q[QB].den == 9'd0) begin
      left_d  = 8'sd0;
      right_d = 8'sd0;
      mode_d  = adm_pkg::MODE_STOP;
    end else begin
      left_d  = mfin(mx_q[QB].lt);
      right_d = mfin(mx_q[QB].rt);
      mode_d  = adm_pkg::MODE_MIX;
    end
  end

  // valid bits travel with the requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= OUTS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k <= OUTS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= QB; k++) begin
        gz_q[k] <= gz_d[k];
        gr_q[k] <= gr_d[k];
        mx_q[k] <= mx_d[k];
      end
      z_q  <= z_d;
      r_q  <= r_d;
      t0_q <= t0_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
      t3_q <= t3_d;
      for (int k = TS; k <= ML; k++) begin
        tipc_q[k] <= tipc_d[k];
      end
      left_q  <= left_d;
      right_q <= right_d;
      mode_q  <= mode_d;
    end
  end

  assign out_valid_o   = vld_q[OUTS];
  assign left_power_o  = left_q;
  assign right_power_o = right_q;
  assign drive_mode_o  = mode_q;

endmodule
